>>> rtl/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg: shared definitions for the demand paging MMU
// Field widths, frame limits, sequencer states and the page table write
// command used by the top level and the page table store.
// ----------------------------------------------------------------------------
package dpm_pkg;

  localparam int VA_W       = 16;
  localparam int PID_W      = 4;
  localparam int VPN_W      = 4;
  localparam int OFF_W      = 10;
  localparam int FRAME_W    = 3;
  localparam int PA_W       = 16;
  localparam int IDX_W      = PID_W + VPN_W;
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 32;

  localparam logic [FRAME_W-1:0] FIRST_FRAME = 3'd3;
  localparam logic [FRAME_W-1:0] LAST_FRAME  = 3'd7;
  localparam logic [FRAME_W-1:0] PTR_RESET   = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_MAP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } tbl_wr_t;

  function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] ptr);
    logic [FRAME_W-1:0] nxt;
    nxt = (ptr >= LAST_FRAME) ? FIRST_FRAME : ptr + 3'd1;
    return nxt;
  endfunction

endpackage

>>> rtl/dpm_table.sv
// ----------------------------------------------------------------------------
// dpm_table: page table store
// Frame numbers live in a memory with one read port and one write port and registered read data.
// Valid bits are flip-flops that reset clears at once.
// ----------------------------------------------------------------------------
module dpm_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dpm_pkg::IDX_W-1:0]     rd_addr,
  input  dpm_pkg::tbl_wr_t              wr,
  output logic                          rd_valid,
  output logic [dpm_pkg::FRAME_W-1:0]   rd_frame
);

  logic [dpm_pkg::FRAME_W-1:0] mem [dpm_pkg::TABLE_SIZE];
  logic [dpm_pkg::TABLE_SIZE-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en && wr.valid) begin
      mem[wr.addr] <= wr.frame;
    end
    rd_frame <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= wr.valid;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

>>> rtl/demand_paging_mmu_fifo.sv
// ----------------------------------------------------------------------------
// demand_paging_mmu_fifo: demand paging MMU with FIFO frame replacement
// Translates user addresses through per-process page tables and evicts
// frames 3 to 7 in FIFO order on a page fault.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. A kernel transaction goes from
// ST_IDLE to ST_FINISH, and a hit passes through ST_READ on the way. A page
// fault passes through ST_READ and ST_MAP when process_count is zero, and
// through ST_READ, ST_SCAN, ST_DRAIN and ST_MAP otherwise, because one
// comparator walks the page tables of processes 1 to process_count through
// the read port of the table memory, one entry per cycle. Every mapped entry
// is accessed and marked modified, so writeback_needed means "a victim was found".
module demand_paging_mmu_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [3:0]                      cfg_wdata,      // process_count
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dpm_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // virtual_address, process_id
  input  logic                            s_axis_tuser,   // kernel_access
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dpm_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // physical_address, load_frame,
                                                          // load_page, writeback_needed,
                                                          // victim_process, victim_page
  output logic                            m_axis_tuser    // page_fault
);

  dpm_pkg::state_t state, state_next;

  logic [3:0]                      pcount;
  logic [dpm_pkg::FRAME_W-1:0]     ptr;
  logic [dpm_pkg::VA_W-1:0]        va;
  logic [dpm_pkg::PID_W-1:0]       pid;
  logic                            kern;
  logic [dpm_pkg::FRAME_W-1:0]     frame;
  logic                            fault;
  logic [dpm_pkg::IDX_W-1:0]       scan_idx;
  logic [dpm_pkg::IDX_W-1:0]       cmp_idx;
  logic                            cmp_en;
  logic                            found;
  logic [dpm_pkg::PID_W-1:0]       vproc;
  logic [dpm_pkg::VPN_W-1:0]       vpage;

  logic                            accept;
  logic                            load_out;
  logic                            cmp_hit;
  logic [dpm_pkg::IDX_W-1:0]       rd_addr;
  logic [dpm_pkg::IDX_W-1:0]       slot;
  logic [dpm_pkg::IDX_W-1:0]       scan_last;
  logic [dpm_pkg::VPN_W-1:0]       vpn;
  logic                            rd_valid;
  logic [dpm_pkg::FRAME_W-1:0]     rd_frame;
  dpm_pkg::tbl_wr_t                tbl_wr;
  logic [dpm_pkg::PA_W-1:0]        pa;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign vpn       = va[dpm_pkg::OFF_W +: dpm_pkg::VPN_W];
  assign slot      = {pid, vpn};
  assign scan_last = {pcount, {dpm_pkg::VPN_W{1'b1}}};
  assign cmp_hit   = cmp_en && rd_valid && (rd_frame == frame);

  dpm_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .wr       (tbl_wr),
    .rd_valid (rd_valid),
    .rd_frame (rd_frame)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      dpm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = s_axis_tuser ? dpm_pkg::ST_FINISH : dpm_pkg::ST_READ;
        end
      end
      dpm_pkg::ST_READ: begin
        if (rd_valid) begin
          state_next = dpm_pkg::ST_FINISH;
        end else if (pcount == 4'd0) begin
          state_next = dpm_pkg::ST_MAP;
        end else begin
          state_next = dpm_pkg::ST_SCAN;
        end
      end
      dpm_pkg::ST_SCAN: begin
        if (scan_idx == scan_last) begin
          state_next = dpm_pkg::ST_DRAIN;
        end
      end
      dpm_pkg::ST_DRAIN:  state_next = dpm_pkg::ST_MAP;
      dpm_pkg::ST_MAP:    state_next = dpm_pkg::ST_FINISH;
      dpm_pkg::ST_FINISH: begin
        if (load_out) begin
          state_next = dpm_pkg::ST_IDLE;
        end
      end
      default: state_next = dpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == dpm_pkg::ST_IDLE);
    load_out      = (state == dpm_pkg::ST_FINISH) && (!m_axis_tvalid || m_axis_tready);
    rd_addr       = (state == dpm_pkg::ST_SCAN) ? scan_idx
                  : {s_axis_tdata[dpm_pkg::VA_W +: dpm_pkg::PID_W],
                     s_axis_tdata[dpm_pkg::OFF_W +: dpm_pkg::VPN_W]};
    tbl_wr        = '0;
    if (state == dpm_pkg::ST_MAP) begin
      tbl_wr.en    = 1'b1;
      tbl_wr.addr  = slot;
      tbl_wr.valid = 1'b1;
      tbl_wr.frame = frame;
    end else if (cmp_hit) begin
      tbl_wr.en    = 1'b1;
      tbl_wr.addr  = cmp_idx;
      tbl_wr.valid = 1'b0;
      tbl_wr.frame = frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dpm_pkg::ST_IDLE;
      pcount <= 4'd0;
      ptr    <= dpm_pkg::PTR_RESET;
      cmp_en <= 1'b0;
      found  <= 1'b0;
      fault  <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= (state == dpm_pkg::ST_SCAN);
      if (cfg_we) begin
        pcount <= cfg_wdata;
      end
      if (accept) begin
        found <= 1'b0;
        fault <= 1'b0;
      end
      if (state == dpm_pkg::ST_READ && !rd_valid) begin
        ptr   <= dpm_pkg::next_frame(ptr);
        fault <= 1'b1;
      end
      if (cmp_hit && !found) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      va    <= s_axis_tdata[dpm_pkg::VA_W-1:0];
      pid   <= s_axis_tdata[dpm_pkg::VA_W +: dpm_pkg::PID_W];
      kern  <= s_axis_tuser;
      vproc <= '0;
      vpage <= '0;
    end
    if (state == dpm_pkg::ST_READ) begin
      frame    <= rd_valid ? rd_frame : dpm_pkg::next_frame(ptr);
      scan_idx <= {{(dpm_pkg::PID_W-1){1'b0}}, 1'b1, {dpm_pkg::VPN_W{1'b0}}};
    end
    if (state == dpm_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 8'd1;
      cmp_idx  <= scan_idx;
    end
    if (cmp_hit && !found) begin
      vproc <= cmp_idx[dpm_pkg::IDX_W-1 -: dpm_pkg::PID_W];
      vpage <= cmp_idx[dpm_pkg::VPN_W-1:0];
    end
  end

  assign pa = kern ? va : {3'b000, frame, va[dpm_pkg::OFF_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tuser <= fault;
      m_axis_tdata <= {vpage, vproc, found,
                       fault ? vpn : 4'd0,
                       fault ? frame : 3'd0,
                       pa};
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr >= dpm_pkg::PTR_RESET && ptr <= dpm_pkg::LAST_FRAME)
    else $error("FIFO pointer left the frame range.");

  a_scan_skips_p0: assert property (@(posedge clk) disable iff (rst)
    state == dpm_pkg::ST_SCAN |-> scan_idx[dpm_pkg::IDX_W-1 -: dpm_pkg::PID_W] != 4'd0)
    else $error("Eviction scan reached the table of process zero.");

  a_map_frame: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en && tbl_wr.valid |-> tbl_wr.frame >= dpm_pkg::FIRST_FRAME)
    else $error("A page was mapped to a reserved frame.");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:16] == 16'd0)
    else $error("A transaction without a fault reports load or victim fields.");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for demand_paging_mmu_fifo
// Drives address translation requests over the input stream, predicts every
// translation with a behavioral page table and FIFO frame pointer kept in the
// testbench, and compares each result transaction field by field. Directed
// tests cover kernel pass-through, hits, faults, pointer wrap and eviction
// scans; random traffic follows under three idling patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic         page_fault;
    logic [3:0]   victim_page;
    logic [3:0]   victim_process;
    logic         writeback_needed;
    logic [3:0]   load_page;
    logic [2:0]   load_frame;
    logic [15:0]  physical_address;
  } xlat_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [3:0]                    cfg_wdata = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [dpm_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [dpm_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tuser;

  logic [5:0]           page_entries [dpm_pkg::TABLE_SIZE];
  logic [2:0]           frame_ptr = dpm_pkg::PTR_RESET;
  logic [3:0]           scan_count = '0;
  xlat_result_t         pending_translations [$];
  int                   errors = 0;
  int                   src_idle_pct = 7;
  int                   sink_idle_pct = 65;
  int                   quiet_cycles = 0;

  demand_paging_mmu_fifo dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    foreach (page_entries[i]) page_entries[i] = '0;
  end

  function automatic xlat_result_t translate_access(input logic [15:0] va,
                                                    input logic [3:0] pid,
                                                    input logic kern);
    xlat_result_t r;
    logic [3:0]   vpn;
    logic [7:0]   slot;
    logic [7:0]   s;
    logic [5:0]   ent;
    logic [5:0]   e;
    logic [2:0]   frame;
    logic         found;
    r = '0;
    if (kern) begin
      r.physical_address = va;
      return r;
    end
    vpn  = va[13:10];
    slot = {pid, vpn};
    ent  = page_entries[slot] | 6'b000011;
    if (!ent[2]) begin
      r.page_fault = 1'b1;
      frame_ptr = (frame_ptr >= dpm_pkg::LAST_FRAME) ? dpm_pkg::FIRST_FRAME
                                                     : frame_ptr + 3'd1;
      frame = frame_ptr;
      found = 1'b0;
      for (int p = 1; p <= int'(scan_count); p++) begin
        for (int g = 0; g < 16; g++) begin
          s = {p[3:0], g[3:0]};
          e = page_entries[s];
          if (e[2] && e[5:3] == frame) begin
            if (!found) begin
              found = 1'b1;
              r.writeback_needed = e[0];
              r.victim_process = p[3:0];
              r.victim_page = g[3:0];
            end
            page_entries[s] = e & 6'b111000;
          end
        end
      end
      ent = {frame, 1'b1, ent[1:0]};
      r.load_frame = frame;
      r.load_page = vpn;
    end
    page_entries[slot] = ent;
    r.physical_address = {3'b000, ent[5:3], va[9:0]};
    return r;
  endfunction

  task automatic send_access(input logic [15:0] va, input logic [3:0] pid,
                             input logic kern);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, pid, va};
    s_axis_tuser  <= kern;
    do @(posedge clk); while (!s_axis_tready);
    pending_translations.push_back(translate_access(va, pid, kern));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_process_count(input logic [3:0] value);
    stop_sending();
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_count = value;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    xlat_result_t want;
    xlat_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (pending_translations.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_translations.pop_front();
        if (got.physical_address !== want.physical_address)
          report_field("physical_address", want.physical_address, got.physical_address);
        if (got.page_fault !== want.page_fault)
          report_field("page_fault", 16'(want.page_fault), 16'(got.page_fault));
        if (got.load_frame !== want.load_frame)
          report_field("load_frame", 16'(want.load_frame), 16'(got.load_frame));
        if (got.load_page !== want.load_page)
          report_field("load_page", 16'(want.load_page), 16'(got.load_page));
        if (got.writeback_needed !== want.writeback_needed)
          report_field("writeback_needed", 16'(want.writeback_needed),
                       16'(got.writeback_needed));
        if (got.victim_process !== want.victim_process)
          report_field("victim_process", 16'(want.victim_process),
                       16'(got.victim_process));
        if (got.victim_page !== want.victim_page)
          report_field("victim_page", 16'(want.victim_page), 16'(got.victim_page));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_kernel_passthrough();
    send_access(16'h0000, 4'd0, 1'b1);
    send_access(16'hFFFF, 4'd15, 1'b1);
  endtask

  task automatic test_fault_then_hit();
    send_access(16'h0000, 4'd0, 1'b0);
    send_access(16'h0155, 4'd0, 1'b0);
    send_access(16'hFFFF, 4'd15, 1'b0);
    send_access(16'h3FFF, 4'd15, 1'b0);
  endtask

  // With no tables scanned, the pointer wraps and leaves duplicate mappings.
  task automatic test_pointer_wrap();
    send_access(16'h0000, 4'd1, 1'b0);
    send_access(16'h0400, 4'd1, 1'b0);
    send_access(16'h0000, 4'd2, 1'b0);
    send_access(16'h0400, 4'd2, 1'b0);
    send_access(16'h0800, 4'd2, 1'b0);
  endtask

  task automatic test_eviction_scan();
    program_process_count(4'd15);
    send_access(16'h0000, 4'd3, 1'b0);
    send_access(16'h0400, 4'd3, 1'b0);
    send_access(16'h0800, 4'd3, 1'b0);
    send_access(16'h0C00, 4'd3, 1'b0);
    send_access(16'h1000, 4'd3, 1'b0);
    send_access(16'h3FFF, 4'd15, 1'b0);
    send_access(16'h0123, 4'd0, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [3:0]  pid;
    logic [3:0]  vpn;
    logic [3:0]  last_pid;
    logic [3:0]  last_vpn;
    logic [15:0] va;
    logic [3:0]  counts [4];
    last_pid = '0;
    last_vpn = '0;
    counts[0] = 4'd15;
    counts[1] = 4'($urandom_range(0, 15));
    counts[2] = 4'd0;
    counts[3] = 4'd1;
    for (int ph = 0; ph < 4; ph++) begin
      program_process_count(counts[ph]);
      for (int n = 0; n < n_items / 4; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          pid = last_pid;
          vpn = last_vpn;
        end else begin
          pid = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
          vpn = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
        end
        va = {2'($urandom_range(0, 3)), vpn, 10'($urandom_range(0, 1023))};
        if ($urandom_range(0, 7) == 0) begin
          send_access(16'($urandom_range(0, 65535)), pid, 1'b1);
        end else begin
          send_access(va, pid, 1'b0);
          last_pid = pid;
          last_vpn = vpn;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_kernel_passthrough();
    test_fault_then_hit();
    test_pointer_wrap();
    test_eviction_scan();
    test_random_traffic(640);
    src_idle_pct  = 65;
    sink_idle_pct = 7;
    test_random_traffic(640);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(640);
    stop_sending();
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dpm_pkg.sv
rtl/dpm_table.sv
rtl/demand_paging_mmu_fifo.sv
tb/sv/tb.sv
